// ===== rtl/ffra_pkg.sv =====
package ffra_pkg;

  localparam int STRIDE_W = 9;
  localparam int OFFSET_W = 18;
  localparam int STATUS_W = 2;
  localparam int CFG_AW   = 3;
  localparam int CFG_DW   = 32;

  localparam logic [STRIDE_W-1:0] STRIDE_RESET = 9'd32;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOFIT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic REG_STRIDE = 1'b0;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_COMPACT,
    S_LARGEST,
    S_FINISH
  } seq_state_t;

endpackage

// ===== rtl/first_fit_range_allocator.sv =====
// First-fit range allocator. A request is taken when start is high and busy is low; busy
// then stays high until the result is ready, and the result appears for exactly one cycle
// with out_strobe high. The receiver cannot stall it, so capture it in that cycle. A new
// request can be taken in the same cycle as the strobe. The free list sits in a small
// memory with one read and one write port, and a sequencer walks it one entry per cycle:
// a first-fit (or merge) scan, a compaction after an exact-fit allocate, a largest-block
// pass, and a final step for the offset multiply. A long scan leaves a short compaction,
// so how long busy stays high after a request is taken is set by the block count and the
// position of the hit, and the result beat follows in the next cycle; zero-sized,
// out-of-page and failed requests finish early.
module first_fit_range_allocator #(
  parameter  int PAGE_SLOTS = 1024,
  parameter  int MAX_BLOCKS = 16,
  localparam int SLOT_W     = $clog2(PAGE_SLOTS),
  localparam int LEN_W      = $clog2(PAGE_SLOTS + 1)
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  logic                            in_kind,
  input  logic [LEN_W-1:0]                in_count,
  input  logic [SLOT_W-1:0]               in_start_slot,
  output logic                            out_strobe,
  output logic [ffra_pkg::STATUS_W-1:0]   out_status,
  output logic [SLOT_W-1:0]               out_slot,
  output logic [ffra_pkg::OFFSET_W-1:0]   out_byte_offset,
  output logic [LEN_W-1:0]                out_largest_free,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ffra_pkg::CFG_AW-1:0]     paddr,
  input  logic [ffra_pkg::CFG_DW-1:0]     pwdata,
  output logic [ffra_pkg::CFG_DW-1:0]     prdata,
  output logic                            pready
);
  import ffra_pkg::*;

  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int ENT_W = SLOT_W + LEN_W;
  localparam int END_W = LEN_W + 1;
  localparam int PROD_W = SLOT_W + STRIDE_W;
  localparam logic [ENT_W-1:0] ENT_RESET = {{SLOT_W{1'b0}}, LEN_W'(PAGE_SLOTS)};

  logic [STRIDE_W-1:0] stride;

  ffra_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .stride  (stride)
  );

  seq_state_t state_r, state_nxt;
  logic                kind_r, kind_nxt;
  logic [LEN_W-1:0]    count_r, count_nxt;
  logic [SLOT_W-1:0]   start_r, start_nxt;
  logic [CNT_W-1:0]    idx_r, idx_nxt;
  logic                dv_r, dv_nxt;
  logic [IDX_W-1:0]    dix_r, dix_nxt;
  logic [CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [LEN_W-1:0]    best_r, best_nxt;
  logic [LEN_W-1:0]    largest_r, largest_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [SLOT_W-1:0]   slot_r, slot_nxt;
  logic [OFFSET_W-1:0] off_r, off_nxt;
  logic                strobe_r, strobe_nxt;
  logic                init0_r, init0_nxt;
  logic                rd_dflt_r;
  logic [ENT_W-1:0]    rd_ent_r;

  logic [ENT_W-1:0]    mem [MAX_BLOCKS];
  logic                we;
  logic [IDX_W-1:0]    wa;
  logic [ENT_W-1:0]    wd;
  logic [IDX_W-1:0]    ra;

  logic [ENT_W-1:0]    ent;
  logic [SLOT_W-1:0]   ent_base;
  logic [LEN_W-1:0]    ent_len;
  logic [END_W-1:0]    in_end;
  logic [END_W-1:0]    free_end;
  logic                hit;
  logic [LEN_W-1:0]    cand;
  logic [PROD_W-1:0]   prod;

  assign ent      = rd_dflt_r ? ENT_RESET : rd_ent_r;
  assign ent_base = ent[ENT_W-1:LEN_W];
  assign ent_len  = ent[LEN_W-1:0];
  assign in_end   = END_W'(in_start_slot) + END_W'(in_count);
  assign free_end = END_W'(start_r) + END_W'(count_r);
  assign hit      = dv_r && ((kind_r == KIND_ALLOC) ? (ent_len >= count_r)
                                                     : (END_W'(ent_base) == free_end));
  assign cand     = (dv_r && ent_len > best_r) ? ent_len : best_r;
  assign prod     = PROD_W'(slot_r) * PROD_W'(stride);

  assign busy             = (state_r != S_IDLE);
  assign out_strobe       = strobe_r;
  assign out_status       = status_r;
  assign out_slot         = slot_r;
  assign out_byte_offset  = off_r;
  assign out_largest_free = largest_r;

  always_comb begin
    state_nxt   = state_r;
    kind_nxt    = kind_r;
    count_nxt   = count_r;
    start_nxt   = start_r;
    idx_nxt     = idx_r;
    dv_nxt      = 1'b0;
    dix_nxt     = dix_r;
    cnt_nxt     = cnt_r;
    best_nxt    = best_r;
    largest_nxt = largest_r;
    status_nxt  = status_r;
    slot_nxt    = slot_r;
    off_nxt     = off_r;
    strobe_nxt  = 1'b0;
    we          = 1'b0;
    wa          = '0;
    wd          = '0;
    ra          = idx_r[IDX_W-1:0];
    case (state_r)
      S_IDLE: begin
        if (start) begin
          kind_nxt   = in_kind;
          count_nxt  = in_count;
          start_nxt  = in_start_slot;
          status_nxt = ST_OK;
          slot_nxt   = '0;
          idx_nxt    = '0;
          if (in_kind == KIND_ALLOC && in_count == '0) begin
            status_nxt = ST_NOFIT;
            state_nxt  = S_FINISH;
          end else if (in_kind == KIND_FREE &&
                       (in_count == '0 || in_end > END_W'(PAGE_SLOTS))) begin
            state_nxt = S_FINISH;
          end else begin
            state_nxt = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (hit) begin
          if (kind_r == KIND_ALLOC) begin
            slot_nxt = ent_base;
            if (ent_len == count_r) begin
              idx_nxt   = CNT_W'(dix_r) + 1'b1;
              state_nxt = S_COMPACT;
            end else begin
              we        = 1'b1;
              wa        = dix_r;
              wd        = {SLOT_W'(ent_base + count_r), LEN_W'(ent_len - count_r)};
              idx_nxt   = '0;
              best_nxt  = '0;
              state_nxt = S_LARGEST;
            end
          end else begin
            we        = 1'b1;
            wa        = dix_r;
            wd        = {start_r, LEN_W'(ent_len + count_r)};
            idx_nxt   = '0;
            best_nxt  = '0;
            state_nxt = S_LARGEST;
          end
        end else if (idx_r < cnt_r) begin
          dv_nxt  = 1'b1;
          dix_nxt = ra;
          idx_nxt = idx_r + 1'b1;
        end else if (kind_r == KIND_ALLOC) begin
          status_nxt = ST_NOFIT;
          state_nxt  = S_FINISH;
        end else if (cnt_r < CNT_W'(MAX_BLOCKS)) begin
          we        = 1'b1;
          wa        = cnt_r[IDX_W-1:0];
          wd        = {start_r, count_r};
          cnt_nxt   = cnt_r + 1'b1;
          idx_nxt   = '0;
          best_nxt  = '0;
          state_nxt = S_LARGEST;
        end else begin
          status_nxt = ST_FULL;
          state_nxt  = S_FINISH;
        end
      end
      S_COMPACT: begin
        if (dv_r) begin
          we = 1'b1;
          wa = dix_r - 1'b1;
          wd = ent;
        end
        if (idx_r < cnt_r) begin
          dv_nxt  = 1'b1;
          dix_nxt = ra;
          idx_nxt = idx_r + 1'b1;
        end else begin
          cnt_nxt   = cnt_r - 1'b1;
          idx_nxt   = '0;
          best_nxt  = '0;
          state_nxt = S_LARGEST;
        end
      end
      S_LARGEST: begin
        best_nxt = cand;
        if (idx_r < cnt_r) begin
          dv_nxt  = 1'b1;
          dix_nxt = ra;
          idx_nxt = idx_r + 1'b1;
        end else begin
          largest_nxt = cand;
          state_nxt   = S_FINISH;
        end
      end
      S_FINISH: begin
        off_nxt    = OFFSET_W'(prod);
        strobe_nxt = 1'b1;
        state_nxt  = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    init0_nxt = init0_r;
    if (we && wa == '0) begin
      init0_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_ent_r <= mem[ra];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      dv_r      <= 1'b0;
      idx_r     <= '0;
      cnt_r     <= CNT_W'(1);
      largest_r <= LEN_W'(PAGE_SLOTS);
      strobe_r  <= 1'b0;
      init0_r   <= 1'b1;
      rd_dflt_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dv_r      <= dv_nxt;
      idx_r     <= idx_nxt;
      cnt_r     <= cnt_nxt;
      largest_r <= largest_nxt;
      strobe_r  <= strobe_nxt;
      init0_r   <= init0_nxt;
      rd_dflt_r <= init0_r && (ra == '0);
    end
  end

  always_ff @(posedge clk) begin
    kind_r   <= kind_nxt;
    count_r  <= count_nxt;
    start_r  <= start_nxt;
    dix_r    <= dix_nxt;
    best_r   <= best_nxt;
    status_r <= status_nxt;
    slot_r   <= slot_nxt;
    off_r    <= off_nxt;
  end

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("result strobe held longer than one cycle");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted request did not raise busy");

  a_strobe_after_finish: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> ($past(state_r) == S_FINISH) && !busy)
    else $error("result strobe without a finished request");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(MAX_BLOCKS))
    else $error("free list count exceeds capacity");

  a_largest_bound: assert property (@(posedge clk) disable iff (!rst_n)
    largest_r <= LEN_W'(PAGE_SLOTS))
    else $error("largest free block exceeds page size");

endmodule

// ===== rtl/ffra_cfg.sv =====
module ffra_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [ffra_pkg::CFG_AW-1:0]     paddr,
  input  logic [ffra_pkg::CFG_DW-1:0]     pwdata,
  output logic [ffra_pkg::CFG_DW-1:0]     prdata,
  output logic                            pready,
  output logic [ffra_pkg::STRIDE_W-1:0]   stride
);
  import ffra_pkg::*;

  logic [STRIDE_W-1:0] stride_r;
  logic [STRIDE_W-1:0] stride_nxt;
  logic                wr_en;
  logic                reg_sel;

  assign reg_sel = paddr[CFG_AW-1];
  assign wr_en   = psel && penable && pwrite && pready;
  assign pready  = 1'b1;
  assign stride  = stride_r;

  always_comb begin
    stride_nxt = stride_r;
    if (wr_en && reg_sel == REG_STRIDE) begin
      stride_nxt = pwdata[STRIDE_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == REG_STRIDE) begin
      prdata = CFG_DW'(stride_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stride_r <= STRIDE_RESET;
    end else begin
      stride_r <= stride_nxt;
    end
  end

endmodule
